// File: hw/rtl/tst_pkg.sv
// Shared widths, result codes and access record of the TCP session state table.
`default_nettype none

package tst_pkg;

    localparam int SID_W   = 10;
    localparam int ST_W    = 4;
    localparam int TAKEN_W = 3;
    localparam int DEST_W  = 2;

    localparam int SESSIONS_DEF   = 1024;
    localparam int STATE_BITS_DEF = 4;

    localparam logic [ST_W-1:0] CLOSED = '0;

    // Which offer a beat consumed
    localparam logic [TAKEN_W-1:0] TAKEN_NONE = 3'd0;
    localparam logic [TAKEN_W-1:0] TAKEN_TX   = 3'd1;
    localparam logic [TAKEN_W-1:0] TAKEN_TXS  = 3'd2;
    localparam logic [TAKEN_W-1:0] TAKEN_RX   = 3'd3;
    localparam logic [TAKEN_W-1:0] TAKEN_TM   = 3'd4;

    // Where the read response goes
    localparam logic [DEST_W-1:0] DEST_NONE = 2'd0;
    localparam logic [DEST_W-1:0] DEST_TX   = 2'd1;
    localparam logic [DEST_W-1:0] DEST_TXS  = 2'd2;
    localparam logic [DEST_W-1:0] DEST_RX   = 2'd3;

    typedef struct packed {
        logic [SID_W-1:0] session;
        logic             write;
        logic [ST_W-1:0]  state;
    } access_t;

endpackage

`default_nettype wire

// File: hw/rtl/tst_req_if.sv
// Request channel: the four offers of one cycle, carried as one beat.
`default_nettype none

interface tst_req_if import tst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             tx_valid;
    logic [SID_W-1:0] tx_session;
    logic             tx_write;
    logic [ST_W-1:0]  tx_state;
    logic             txs_valid;
    logic [SID_W-1:0] txs_session;
    logic             rx_valid;
    logic [SID_W-1:0] rx_session;
    logic             rx_write;
    logic [ST_W-1:0]  rx_state;
    logic             tm_valid;
    logic [SID_W-1:0] tm_session;

    modport source (
        output valid, tx_valid, tx_session, tx_write, tx_state, txs_valid, txs_session,
               rx_valid, rx_session, rx_write, rx_state, tm_valid, tm_session,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_session, tx_write, tx_state, txs_valid, txs_session,
               rx_valid, rx_session, rx_write, rx_state, tm_valid, tm_session,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/tst_rsp_if.sv
// Result channel: one beat per request beat.
`default_nettype none

interface tst_rsp_if import tst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TAKEN_W-1:0] taken;
    logic [DEST_W-1:0]  rsp_dest;
    logic [ST_W-1:0]    rsp_state;
    logic               release_valid;
    logic [SID_W-1:0]   release_session;

    modport source (
        output valid, taken, rsp_dest, rsp_state, release_valid, release_session,
        input  ready
    );
    modport sink (
        input  valid, taken, rsp_dest, rsp_state, release_valid, release_session,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/tcp_session_state_table.sv
// TCP session state table: per-session state memory with TX/RX locking and close timer.
//
// Channels: req (sink) carries one beat holding all four offers of a cycle (TX access,
// TX stream read, RX access, timer close); rsp (source) returns exactly one beat per
// request beat: which offer was taken, the read response and any session release.
// Offers that are not taken stay with their source and are simply offered again.
//
// Flow: a request beat is accepted in the idle state. On that edge the lock and
// parking registers update, a write goes to the state memory and a read is issued.
// The result register then loads from the registered read data once it is free or
// being emptied, and rsp.valid rises. No new request is taken until that load: the
// read of the state memory sets the pace, and the next request waits for it.
//
// Reset: locks and parked accesses clear at once; then a clearing pass writes CLOSED
// into every entry, one entry a cycle, with req.ready low.
//
// Stall: a finished result waits in the result register while rsp.ready is low, and a
// new request is still accepted meanwhile; its result is held back until the slot frees.
`default_nettype none

module tcp_session_state_table import tst_pkg::*; #(
    parameter int SESSIONS   = SESSIONS_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tst_req_if.sink    req,
    tst_rsp_if.source  rsp
);

    localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_TX,
        K_TXS,
        K_RX,
        K_CL
    } kind_t;

    typedef struct packed {
        logic [TAKEN_W-1:0] taken;
        logic [DEST_W-1:0]  dest;
        logic               in_range;
        logic               rel_valid;
        logic [SID_W-1:0]   rel_session;
    } res_t;

    state_t state_reg, state_next;

    // lock and parking registers
    logic             tx_lock_held_reg, tx_lock_held_next;
    logic [SID_W-1:0] tx_lock_session_reg, tx_lock_session_next;
    logic             rx_lock_held_reg, rx_lock_held_next;
    logic [SID_W-1:0] rx_lock_session_reg, rx_lock_session_next;
    logic             tx_parked_reg, tx_parked_next;
    access_t          tx_parked_access_reg, tx_parked_access_next;
    logic             rx_parked_reg, rx_parked_next;
    access_t          rx_parked_access_reg, rx_parked_access_next;
    logic             close_parked_reg, close_parked_next;
    logic [SID_W-1:0] close_parked_session_reg, close_parked_session_next;

    logic [AW-1:0]    clr_idx_reg, clr_idx_next;
    res_t             res_reg, res_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [TAKEN_W-1:0] out_taken_reg;
    logic [DEST_W-1:0]  out_dest_reg;
    logic [ST_W-1:0]    out_state_reg;
    logic               out_rel_valid_reg;
    logic [SID_W-1:0]   out_rel_session_reg;

    // state memory
    logic [STATE_BITS-1:0] session_mem [SESSIONS];
    logic [STATE_BITS-1:0] mem_rd_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [STATE_BITS-1:0] mem_wdata;

    logic               accept;
    logic               out_load;
    kind_t              kind;
    access_t            op;
    logic [TAKEN_W-1:0] taken;
    logic               tx_hit;
    logic               rx_hit;
    logic               blocked;
    logic               in_range;
    logic               op_we;
    logic               op_re;
    logic [AW+SID_W-1:0] sid_wide;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    // Select the one access served this beat
    always_comb
    begin
        kind  = K_NONE;
        taken = TAKEN_NONE;
        op    = '0;
        priority if (req.tx_valid && !tx_parked_reg)
        begin
            kind  = K_TX;
            taken = TAKEN_TX;
            op    = '{session: req.tx_session, write: req.tx_write, state: req.tx_state};
        end
        else if (req.txs_valid)
        begin
            kind  = K_TXS;
            taken = TAKEN_TXS;
            op    = '{session: req.txs_session, write: 1'b0, state: CLOSED};
        end
        else if (req.rx_valid && !rx_parked_reg)
        begin
            kind  = K_RX;
            taken = TAKEN_RX;
            op    = '{session: req.rx_session, write: req.rx_write, state: req.rx_state};
        end
        else if (req.tm_valid && !close_parked_reg)
        begin
            kind  = K_CL;
            taken = TAKEN_TM;
            op    = '{session: req.tm_session, write: 1'b1, state: CLOSED};
        end
        else if (tx_parked_reg)
        begin
            kind = K_TX;
            op   = tx_parked_access_reg;
        end
        else if (rx_parked_reg)
        begin
            kind = K_RX;
            op   = rx_parked_access_reg;
        end
        else if (close_parked_reg)
        begin
            kind = K_CL;
            op   = '{session: close_parked_session_reg, write: 1'b1, state: CLOSED};
        end
        else
        begin
            kind = K_NONE;
        end
    end

    assign tx_hit   = tx_lock_held_reg && (tx_lock_session_reg == op.session);
    assign rx_hit   = rx_lock_held_reg && (rx_lock_session_reg == op.session);
    assign in_range = (32'(op.session) < SESSIONS);
    assign sid_wide = {{AW{1'b0}}, op.session};

    always_comb
    begin
        unique case (kind)
            K_TX:    blocked = rx_hit;
            K_RX:    blocked = tx_hit;
            K_CL:    blocked = rx_hit || tx_hit;
            default: blocked = 1'b0;
        endcase
    end

    // Effect of the selected access
    always_comb
    begin
        tx_lock_held_next         = tx_lock_held_reg;
        tx_lock_session_next      = tx_lock_session_reg;
        rx_lock_held_next         = rx_lock_held_reg;
        rx_lock_session_next      = rx_lock_session_reg;
        tx_parked_next            = tx_parked_reg;
        tx_parked_access_next     = tx_parked_access_reg;
        rx_parked_next            = rx_parked_reg;
        rx_parked_access_next     = rx_parked_access_reg;
        close_parked_next         = close_parked_reg;
        close_parked_session_next = close_parked_session_reg;
        op_we                     = 1'b0;
        op_re                     = 1'b0;
        res_next                  = '{taken: taken, dest: DEST_NONE, in_range: in_range,
                                      rel_valid: 1'b0, rel_session: '0};
        unique case (kind)
            K_TX:
            begin
                tx_parked_next        = blocked;
                tx_parked_access_next = op;
                if (!blocked)
                begin
                    if (op.write)
                    begin
                        op_we             = 1'b1;
                        tx_lock_held_next = 1'b0;
                    end
                    else
                    begin
                        op_re                = 1'b1;
                        res_next.dest        = DEST_TX;
                        tx_lock_session_next = op.session;
                        tx_lock_held_next    = 1'b1;
                    end
                end
            end
            K_TXS:
            begin
                op_re         = 1'b1;
                res_next.dest = DEST_TXS;
            end
            K_RX:
            begin
                rx_parked_next        = blocked;
                rx_parked_access_next = op;
                if (!blocked)
                begin
                    if (op.write)
                    begin
                        op_we             = 1'b1;
                        rx_lock_held_next = 1'b0;
                        if (op.state == CLOSED)
                        begin
                            res_next.rel_valid   = 1'b1;
                            res_next.rel_session = op.session;
                        end
                    end
                    else
                    begin
                        op_re                = 1'b1;
                        res_next.dest        = DEST_RX;
                        rx_lock_session_next = op.session;
                        rx_lock_held_next    = 1'b1;
                    end
                end
            end
            K_CL:
            begin
                close_parked_next         = blocked;
                close_parked_session_next = op.session;
                if (!blocked)
                begin
                    op_we                = 1'b1;
                    res_next.rel_valid   = 1'b1;
                    res_next.rel_session = op.session;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Memory port: clearing pass, else the accepted access
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_re    = 1'b0;
            mem_addr  = clr_idx_reg;
            mem_wdata = STATE_BITS'(CLOSED);
        end
        else
        begin
            mem_we    = accept && op_we && in_range;
            mem_re    = accept && op_re;
            mem_addr  = sid_wide[AW-1:0];
            mem_wdata = STATE_BITS'(op.state);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            session_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= session_mem[mem_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(SESSIONS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= S_CLEAR;
            clr_idx_reg              <= '0;
            out_valid_reg            <= 1'b0;
            tx_lock_held_reg         <= 1'b0;
            tx_lock_session_reg      <= '0;
            rx_lock_held_reg         <= 1'b0;
            rx_lock_session_reg      <= '0;
            tx_parked_reg            <= 1'b0;
            tx_parked_access_reg     <= '0;
            rx_parked_reg            <= 1'b0;
            rx_parked_access_reg     <= '0;
            close_parked_reg         <= 1'b0;
            close_parked_session_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                tx_lock_held_reg         <= tx_lock_held_next;
                tx_lock_session_reg      <= tx_lock_session_next;
                rx_lock_held_reg         <= rx_lock_held_next;
                rx_lock_session_reg      <= rx_lock_session_next;
                tx_parked_reg            <= tx_parked_next;
                tx_parked_access_reg     <= tx_parked_access_next;
                rx_parked_reg            <= rx_parked_next;
                rx_parked_access_reg     <= rx_parked_access_next;
                close_parked_reg         <= close_parked_next;
                close_parked_session_reg <= close_parked_session_next;
            end
        end
    end

    // Pending result and result register (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_taken_reg       <= res_reg.taken;
            out_dest_reg        <= res_reg.dest;
            out_state_reg       <= (res_reg.dest != DEST_NONE && res_reg.in_range)
                                   ? mem_rd_reg[ST_W-1:0] : CLOSED;
            out_rel_valid_reg   <= res_reg.rel_valid;
            out_rel_session_reg <= res_reg.rel_session;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.taken           = out_taken_reg;
    assign rsp.rsp_dest        = out_dest_reg;
    assign rsp.rsp_state       = out_state_reg;
    assign rsp.release_valid   = out_rel_valid_reg;
    assign rsp.release_session = out_rel_session_reg;

    // The two sides never lock the same session
    a_lock_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tx_lock_held_reg && rx_lock_held_reg && tx_lock_session_reg == rx_lock_session_reg))
        else $error("both sides hold a lock on one session");

    // State memory is never written while a result is being formed
    a_no_exec_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_IDLE))
        else $error("state memory written outside clear or accept");

    // Forming a result always fills the slot and frees the sequencer
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not registered after execution");

    // A release never comes with a read response
    a_rel_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rel_valid_reg) |-> (out_dest_reg == DEST_NONE))
        else $error("release beat carries a read response");

endmodule

`default_nettype wire

// File: test/tcp_session_state_table_checker.sv
// Watches both channels of the session state table, predicts every result beat and checks it.
module tcp_session_state_table_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    tst_req_if        req,
    tst_rsp_if        rsp,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tst_pkg::*;

    typedef struct packed {
        logic [TAKEN_W-1:0] taken;
        logic [DEST_W-1:0]  dest;
        logic [ST_W-1:0]    state;
        logic               rel;
        logic [SID_W-1:0]   rel_sid;
    } table_result_t;

    // Own copy of the table, locks and parked accesses
    logic [ST_W-1:0]  state_mem [SESSIONS_DEF];
    logic [SID_W-1:0] tx_lock_sid, rx_lock_sid, close_sid;
    logic             tx_lock_on, rx_lock_on;
    logic             tx_wait, rx_wait, close_wait;
    access_t          tx_wait_acc, rx_wait_acc;

    table_result_t    now_res;
    table_result_t    want;
    table_result_t    results_due [$];
    int               bad = 0;

    function automatic logic tx_holds(input logic [SID_W-1:0] sid);
        return tx_lock_on && tx_lock_sid == sid;
    endfunction

    function automatic logic rx_holds(input logic [SID_W-1:0] sid);
        return rx_lock_on && rx_lock_sid == sid;
    endfunction

    function automatic void run_tx(input access_t a);
        if (a.write) begin
            state_mem[a.session] = a.state;
            tx_lock_on = 1'b0;
        end else begin
            now_res.dest  = DEST_TX;
            now_res.state = state_mem[a.session];
            tx_lock_sid   = a.session;
            tx_lock_on    = 1'b1;
        end
    endfunction

    function automatic void run_rx(input access_t a);
        if (a.write) begin
            if (a.state == CLOSED) begin
                now_res.rel     = 1'b1;
                now_res.rel_sid = a.session;
            end
            state_mem[a.session] = a.state;
            rx_lock_on = 1'b0;
        end else begin
            now_res.dest  = DEST_RX;
            now_res.state = state_mem[a.session];
            rx_lock_sid   = a.session;
            rx_lock_on    = 1'b1;
        end
    endfunction

    function automatic void run_close(input logic [SID_W-1:0] sid);
        state_mem[sid]  = CLOSED;
        now_res.rel     = 1'b1;
        now_res.rel_sid = sid;
    endfunction

    // One request beat in, one result beat out; priority as in the table
    function automatic table_result_t serve_offers(
        input logic tx_v, input access_t tx_acc,
        input logic txs_v, input logic [SID_W-1:0] txs_sid,
        input logic rx_v, input access_t rx_acc,
        input logic tm_v, input logic [SID_W-1:0] tm_sid
    );
        now_res = '0;
        if (tx_v && !tx_wait) begin
            now_res.taken = TAKEN_TX;
            tx_wait_acc   = tx_acc;
            if (rx_holds(tx_acc.session))
                tx_wait = 1'b1;
            else
                run_tx(tx_acc);
        end else if (txs_v) begin
            now_res.taken = TAKEN_TXS;
            now_res.dest  = DEST_TXS;
            now_res.state = state_mem[txs_sid];
        end else if (rx_v && !rx_wait) begin
            now_res.taken = TAKEN_RX;
            rx_wait_acc   = rx_acc;
            if (tx_holds(rx_acc.session))
                rx_wait = 1'b1;
            else
                run_rx(rx_acc);
        end else if (tm_v && !close_wait) begin
            now_res.taken = TAKEN_TM;
            close_sid     = tm_sid;
            if (rx_holds(tm_sid) || tx_holds(tm_sid))
                close_wait = 1'b1;
            else
                run_close(tm_sid);
        end else if (tx_wait) begin
            if (!rx_holds(tx_wait_acc.session)) begin
                run_tx(tx_wait_acc);
                tx_wait = 1'b0;
            end
        end else if (rx_wait) begin
            if (!tx_holds(rx_wait_acc.session)) begin
                run_rx(rx_wait_acc);
                rx_wait = 1'b0;
            end
        end else if (close_wait) begin
            if (!rx_holds(close_sid) && !tx_holds(close_sid)) begin
                run_close(close_sid);
                close_wait = 1'b0;
            end
        end
        return now_res;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                          input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            bad++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < SESSIONS_DEF; i++)
                state_mem[i] = CLOSED;
            tx_lock_sid = '0;
            rx_lock_sid = '0;
            close_sid   = '0;
            tx_lock_on  = 1'b0;
            rx_lock_on  = 1'b0;
            tx_wait     = 1'b0;
            rx_wait     = 1'b0;
            close_wait  = 1'b0;
            tx_wait_acc = '0;
            rx_wait_acc = '0;
            results_due.delete();
        end else begin
            // result side first: a beat accepted now belongs to an older request
            if (rsp.valid && rsp.ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with no request waiting for it");
                    bad++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("taken", 16'(want.taken), 16'(rsp.taken));
                    compare_field("rsp_dest", 16'(want.dest), 16'(rsp.rsp_dest));
                    compare_field("rsp_state", 16'(want.state), 16'(rsp.rsp_state));
                    compare_field("release_valid", 16'(want.rel), 16'(rsp.release_valid));
                    compare_field("release_session", 16'(want.rel_sid),
                                  16'(rsp.release_session));
                end
            end
            if (req.valid && req.ready)
                results_due.push_back(serve_offers(
                    req.tx_valid, access_t'{req.tx_session, req.tx_write, req.tx_state},
                    req.txs_valid, req.txs_session,
                    req.rx_valid, access_t'{req.rx_session, req.rx_write, req.rx_state},
                    req.tm_valid, req.tm_session));
        end
        mismatches  <= bad;
        outstanding <= results_due.size();
    end

endmodule

// File: test/tcp_session_state_table_tb.sv
// Top of the session state table testbench: clock, reset, request stimulus, stalls, verdict.
module tcp_session_state_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tst_pkg::*;

    // Nothing accepted on either side for this long means a hang. Covers the
    // clearing pass after reset (one entry per cycle) with a wide margin.
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_BEATS = 1000;

    localparam logic DO_WRITE = 1'b1;
    localparam logic DO_READ  = 1'b0;

    // Small session pools so that locks actually collide. TX reads live in
    // the low pool, RX reads in the high one; both ends of the index range.
    localparam logic [SID_W-1:0] TX_POOL = 10'd0;
    localparam logic [SID_W-1:0] RX_POOL = 10'd1020;
    localparam logic [SID_W-1:0] TOP_SID = '1;

    // All four offers of one request beat
    typedef struct packed {
        logic             tx_v;
        access_t          tx;
        logic             txs_v;
        logic [SID_W-1:0] txs_sid;
        logic             rx_v;
        access_t          rx;
        logic             tm_v;
        logic [SID_W-1:0] tm_sid;
    } offer_t;

    localparam offer_t NO_OFFER = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;   // phase without any idling on either side
    int   fails;
    int   awaiting;
    int   quiet = 0;

    tst_req_if req_ch ();
    tst_rsp_if rsp_ch ();

    tcp_session_state_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    tcp_session_state_table_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (fails),
        .outstanding (awaiting)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic offer_t with_tx(input offer_t o, input logic [SID_W-1:0] sid,
                                       input logic wr, input logic [ST_W-1:0] st);
        o.tx_v = 1'b1;
        o.tx   = access_t'{sid, wr, st};
        return o;
    endfunction

    function automatic offer_t with_txs(input offer_t o, input logic [SID_W-1:0] sid);
        o.txs_v   = 1'b1;
        o.txs_sid = sid;
        return o;
    endfunction

    function automatic offer_t with_rx(input offer_t o, input logic [SID_W-1:0] sid,
                                       input logic wr, input logic [ST_W-1:0] st);
        o.rx_v = 1'b1;
        o.rx   = access_t'{sid, wr, st};
        return o;
    endfunction

    function automatic offer_t with_tm(input offer_t o, input logic [SID_W-1:0] sid);
        o.tm_v   = 1'b1;
        o.tm_sid = sid;
        return o;
    endfunction

    function automatic logic [SID_W-1:0] pool_sid(input logic [SID_W-1:0] base);
        return base + SID_W'($urandom_range(0, 3));
    endfunction

    // Anywhere: either pool, or the whole index range now and then
    function automatic logic [SID_W-1:0] any_sid();
        int r = $urandom_range(0, 99);
        if (r < 35)
            return pool_sid(TX_POOL);
        if (r < 70)
            return pool_sid(RX_POOL);
        return SID_W'($urandom_range(0, 1023));
    endfunction

    // Read target of the leading side: its own pool or the middle of the range,
    // never the other side's pool
    function automatic logic [SID_W-1:0] lead_read_sid(input logic [SID_W-1:0] base);
        if ($urandom_range(0, 9) < 7)
            return pool_sid(base);
        return SID_W'($urandom_range(4, 1019));
    endfunction

    // A parked TX plus a parked RX lock each other out for good, so only one side
    // may reach into the other's locks within a phase. The leading side reads in
    // its own pool (or the middle) and writes anywhere; the other side stays in
    // its own pool. Fields of offers that are not made still carry random bits.
    function automatic offer_t random_offer(input bit tx_leads);
        offer_t o;
        o.tx      = access_t'(15'($urandom()));
        o.rx      = access_t'(15'($urandom()));
        o.txs_sid = SID_W'($urandom());
        o.tm_sid  = SID_W'($urandom());
        if (tx_leads) begin
            o.tx.session = o.tx.write ? any_sid() : lead_read_sid(TX_POOL);
            o.rx.session = pool_sid(RX_POOL);
        end else begin
            o.tx.session = pool_sid(TX_POOL);
            o.rx.session = o.rx.write ? any_sid() : lead_read_sid(RX_POOL);
        end
        if (o.rx.write && $urandom_range(0, 3) == 0)
            o.rx.state = CLOSED;
        if ($urandom_range(0, 1) == 0)
            o.txs_sid = any_sid();
        if ($urandom_range(0, 3) != 0)
            o.tm_sid = any_sid();
        // an empty beat lets parked accesses retry
        if ($urandom_range(0, 99) < 15) begin
            o.tx_v  = 1'b0;
            o.txs_v = 1'b0;
            o.rx_v  = 1'b0;
            o.tm_v  = 1'b0;
        end else begin
            o.tx_v  = $urandom_range(0, 99) < 45;
            o.txs_v = $urandom_range(0, 99) < 20;
            o.rx_v  = $urandom_range(0, 99) < 50;
            o.tm_v  = $urandom_range(0, 99) < 15;
        end
        return o;
    endfunction

    task automatic drive_offer(input offer_t o);
        req_ch.tx_valid    <= o.tx_v;
        req_ch.tx_session  <= o.tx.session;
        req_ch.tx_write    <= o.tx.write;
        req_ch.tx_state    <= o.tx.state;
        req_ch.txs_valid   <= o.txs_v;
        req_ch.txs_session <= o.txs_sid;
        req_ch.rx_valid    <= o.rx_v;
        req_ch.rx_session  <= o.rx.session;
        req_ch.rx_write    <= o.rx.write;
        req_ch.rx_state    <= o.rx.state;
        req_ch.tm_valid    <= o.tm_v;
        req_ch.tm_session  <= o.tm_sid;
    endtask

    // Offer one beat and hold it until the table takes it. Valid only drops
    // when a gap follows, so it never falls and rises within one step.
    task automatic send(input offer_t o);
        int gap = gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        drive_offer(o);
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Result side: ready in runs of random length, broken by stalls
    initial
    begin
        int hold;
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever begin
            rsp_ch.ready <= 1'b1;
            hold = $urandom_range(1, 20);
            repeat (hold) @(posedge clk);
            stall = gap_len();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: counts cycles in which neither side accepts a beat
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    initial
    begin
        int left;
        int len;
        bit tx_leads;

        req_ch.valid <= 1'b0;
        drive_offer(NO_OFFER);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: both index extremes, every offer kind, parking and retries
        send(with_txs(NO_OFFER, TOP_SID));                        // fresh table reads CLOSED
        send(with_tx(NO_OFFER, 10'd0, DO_WRITE, 4'd15));
        send(with_rx(NO_OFFER, TOP_SID, DO_WRITE, 4'd15));
        send(with_txs(NO_OFFER, 10'd0));
        send(with_tx(NO_OFFER, 10'd0, DO_READ, 4'd0));            // TX locks 0
        send(with_rx(NO_OFFER, TOP_SID, DO_READ, 4'd0));          // RX locks top index
        send(with_rx(NO_OFFER, 10'd0, DO_WRITE, 4'd5));           // RX parks behind TX lock
        // RX offer ignored while RX is parked; the close is taken but parks too
        send(with_tm(with_rx(NO_OFFER, TOP_SID, DO_READ, 4'd0), 10'd0));
        send(NO_OFFER);                                           // retry still blocked
        send(with_txs(with_tx(NO_OFFER, 10'd0, DO_WRITE, 4'd9), 10'd5));
        send(NO_OFFER);                                           // parked RX write goes
        send(NO_OFFER);                                           // parked close goes
        send(with_rx(NO_OFFER, TOP_SID, DO_READ, 4'd0));
        send(with_tx(NO_OFFER, TOP_SID, DO_WRITE, 4'd3));         // TX parks behind RX
        // TX offer ignored while parked; RX writes CLOSED and releases
        send(with_rx(with_tx(NO_OFFER, 10'd5, DO_READ, 4'd0), TOP_SID, DO_WRITE, CLOSED));
        send(NO_OFFER);
        send(with_rx(NO_OFFER, 10'd2, DO_READ, 4'd0));
        send(with_tx(NO_OFFER, 10'd2, DO_READ, 4'd0));            // parked read
        send(with_rx(NO_OFFER, 10'd2, DO_WRITE, CLOSED));
        send(NO_OFFER);                                           // retried read answers TX
        send(with_tm(NO_OFFER, TOP_SID));                         // close with no lock
        send(with_tx(NO_OFFER, 10'd2, DO_WRITE, 4'd10));
        send(with_tm(with_rx(with_txs(with_tx(NO_OFFER, TOP_SID, DO_WRITE, 4'd15), TOP_SID),
                             TOP_SID, DO_WRITE, 4'd15), TOP_SID));
        send(with_tm(with_rx(with_txs(NO_OFFER, TOP_SID), TOP_SID, DO_READ, 4'd0), 10'd0));

        // Random phases, each led by one side, each closed by beats that free
        // every lock and let parked accesses through
        left = RANDOM_BEATS;
        while (left > 0) begin
            len = $urandom_range(40, 150);
            if (len > left)
                len = left;
            tx_leads = $urandom_range(0, 1);
            steady   = $urandom_range(0, 3) == 0;
            repeat (len) send(random_offer(tx_leads));
            send(with_rx(NO_OFFER, pool_sid(RX_POOL), DO_WRITE, 4'($urandom())));
            send(NO_OFFER);
            send(with_tx(NO_OFFER, pool_sid(TX_POOL), DO_WRITE, 4'($urandom())));
            send(NO_OFFER);
            send(with_rx(NO_OFFER, pool_sid(RX_POOL), DO_WRITE, 4'($urandom())));
            send(with_tx(NO_OFFER, pool_sid(TX_POOL), DO_WRITE, 4'($urandom())));
            send(NO_OFFER);
            send(NO_OFFER);
            left -= len;
        end
        req_ch.valid <= 1'b0;

        // Wait for the last results, then keep watching for stray beats
        while (awaiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: tcp_session_state_table.f
hw/rtl/tst_pkg.sv
hw/rtl/tst_req_if.sv
hw/rtl/tst_rsp_if.sv
hw/rtl/tcp_session_state_table.sv
test/tcp_session_state_table_checker.sv
test/tcp_session_state_table_tb.sv
